/* rtl/core/mcfir_pkg.sv */
// Shared types and fixed field widths for the multichannel FIR filter.
package mcfir_pkg;

  // Fixed field widths of the item formats
  localparam int CHAN_W   = 3;
  localparam int CIDX_W   = 6;
  localparam int TAPCFG_W = 7;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MAC   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } mcfir_state_t;

  // Control broadcast to every tap cell
  typedef struct packed {
    logic load;     // sample item taken: write delay line, load tap registers
    logic shift;    // rotate coefficient ring by one place
    logic coef_we;  // coefficient item taken
  } mcfir_cell_ctrl_t;

  // Control of the multiply-accumulate unit
  typedef struct packed {
    logic clear;    // start a new sum
    logic mul_en;   // a valid pair is at the multiplier inputs
  } mcfir_mac_ctrl_t;

endpackage

/* rtl/core/mcfir_cell.sv */
// One tap cell: a coefficient ring stage and the delay-line column of every channel.
module mcfir_cell #(
  parameter int MAX_TAPS    = 64,
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 24,
  parameter int J           = 0
) (
  input  logic                                 clk,
  input  mcfir_pkg::mcfir_cell_ctrl_t          ctrl,
  input  logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] taps_m1,
  input  logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] wr_pos,
  input  logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] coef_idx,
  input  logic [$clog2(MAX_TAPS+1)-1:0]        fill,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] ch_idx,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic signed [SAMPLE_BITS-1:0]        coef_wdata,
  input  logic signed [SAMPLE_BITS-1:0]        next_coef,
  input  logic signed [SAMPLE_BITS-1:0]        head_coef,
  output logic signed [SAMPLE_BITS-1:0]        coef_o,
  output logic signed [SAMPLE_BITS-1:0]        x_o
);
  import mcfir_pkg::*;

  localparam int POS_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TAP_W = $clog2(MAX_TAPS+1);

  logic signed [SAMPLE_BITS-1:0] mem [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] coef_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic                          write_here;
  logic                          written;
  logic                          in_ring;
  logic                          ring_end;

  assign write_here = ctrl.load && (wr_pos == POS_W'(J));
  // entries at or past the channel's fill mark were never written and read as zero
  assign written    = (TAP_W'(J) < fill);
  assign in_ring    = (POS_W'(J) <= taps_m1);
  assign ring_end   = (POS_W'(J) == taps_m1);

  // delay-line column, registered read of the selected channel
  always_ff @(posedge clk) begin
    if (write_here) begin
      mem[ch_idx] <= sample;
    end
    if (ctrl.load) begin
      if (write_here) begin
        x_r <= sample;
      end else if (written) begin
        x_r <= mem[ch_idx];
      end else begin
        x_r <= '0;
      end
    end
  end

  // coefficient ring stage: last active cell wraps from the head
  always_ff @(posedge clk) begin
    if (ctrl.coef_we && (coef_idx == POS_W'(J))) begin
      coef_r <= coef_wdata;
    end else if (ctrl.shift && in_ring) begin
      coef_r <= ring_end ? head_coef : next_coef;
    end
  end

  assign coef_o = coef_r;
  assign x_o    = x_r;

endmodule

/* rtl/core/mcfir_mac.sv */
// Multiply-accumulate unit with round-half-up and saturation to the sample format.
module mcfir_mac #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mcfir_pkg::mcfir_mac_ctrl_t    ctrl,
  input  logic signed [SAMPLE_BITS-1:0] coef,
  input  logic signed [SAMPLE_BITS-1:0] x,
  output logic signed [SAMPLE_BITS-1:0] result
);
  import mcfir_pkg::*;

  localparam int FRAC  = SAMPLE_BITS - 1;
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int ACC_W = PROD_W + $clog2(MAX_TAPS+1);
  localparam int VW    = ACC_W + 1;
  localparam logic signed [VW-1:0] HALF =
    {{(VW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
  localparam logic signed [VW-1:0] QMAX =
    {{(VW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [VW-1:0] QMIN =
    {{(VW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_v_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [VW-1:0]     rnd;
  logic signed [VW-1:0]     q;

  // product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctrl.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= coef * x;
    end
  end

  // accumulator, wide enough that a full sum never overflows
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // round half up, then clamp to the sample range
  always_comb begin
    rnd = VW'(acc_r) + HALF;
    q   = rnd >>> FRAC;
    priority if (q > QMAX) begin
      result = QMAX[SAMPLE_BITS-1:0];
    end else if (q < QMIN) begin
      result = QMIN[SAMPLE_BITS-1:0];
    end else begin
      result = q[SAMPLE_BITS-1:0];
    end
  end

endmodule

/* rtl/core/multichannel_fir_filter.sv */
// Top level of the multichannel FIR filter: item decode, sequencer, tap cells and MAC.
//
// Shared-coefficient FIR for up to CHANNELS channels, each with a circular delay line
// of up to MAX_TAPS samples, all in signed Q1.23 (SAMPLE_BITS wide). An input item with
// in_tuser high loads one coefficient and leaves the block idle. An item with in_tuser
// low filters one sample and gives one result item; it is taken in the idle state, then
// the MAC state rotates the coefficient ring one place per cycle past a single
// multiply-accumulate unit, once per tap in use (T, 1..MAX_TAPS); the drain state
// closes the sum and the emit state hands it to the output register. The output
// register lets the next item in while a result waits. Samples for a channel number at
// or above CHANNELS are dropped without a result. Delay lines read as zero after reset
// through a per-channel fill mark, so no clearing pass is needed. Coefficients must be
// loaded before use. Write tap_count only while the block is idle.
module multichannel_fir_filter #(
  parameter int MAX_TAPS    = 64,
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata, lowest bit first: channel, sample, coeff_index, coeff_value, zero fill
  input  logic [((2*SAMPLE_BITS+mcfir_pkg::CHAN_W+mcfir_pkg::CIDX_W+7)/8)*8-1:0] in_tdata,
  // in_tuser: action (0 = filter sample, 1 = load coefficient)
  input  logic                                   in_tuser,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // out_tdata, lowest bit first: out_channel, filtered_sample, zero fill
  output logic [((SAMPLE_BITS+mcfir_pkg::CHAN_W+7)/8)*8-1:0] out_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic                                   cfg_wen,
  input  logic [mcfir_pkg::TAPCFG_W-1:0]         cfg_wdata
);
  import mcfir_pkg::*;

  localparam int OUT_DW = ((SAMPLE_BITS+CHAN_W+7)/8)*8;
  localparam int POS_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TAP_W  = $clog2(MAX_TAPS+1);
  localparam int TCW    = (TAP_W > TAPCFG_W) ? TAP_W : TAPCFG_W;
  localparam int CH_IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHX    = ((CH_IW > CHAN_W) ? CH_IW : CHAN_W) + 1;
  localparam int IXW    = ((POS_W > CIDX_W) ? POS_W : CIDX_W) + 1;
  localparam int OFS_SMP  = CHAN_W;
  localparam int OFS_CIDX = CHAN_W + SAMPLE_BITS;
  localparam int OFS_CVAL = CHAN_W + SAMPLE_BITS + CIDX_W;

  // input item fields
  logic [CHAN_W-1:0]             in_ch;
  logic signed [SAMPLE_BITS-1:0] in_smp;
  logic [CIDX_W-1:0]             in_cidx;
  logic signed [SAMPLE_BITS-1:0] in_cval;

  assign in_ch   = in_tdata[CHAN_W-1:0];
  assign in_smp  = in_tdata[OFS_SMP +: SAMPLE_BITS];
  assign in_cidx = in_tdata[OFS_CIDX +: CIDX_W];
  assign in_cval = in_tdata[OFS_CVAL +: SAMPLE_BITS];

  mcfir_state_t          state_r, state_nxt;
  logic [TAPCFG_W-1:0]   tap_r;
  logic [POS_W-1:0]      pos_tab_r  [CHANNELS];
  logic [TAP_W-1:0]      fill_tab_r [CHANNELS];
  logic [POS_W-1:0]      taps_m1_r, taps_m1_nxt;
  logic [POS_W-1:0]      at_r, at_nxt;
  logic [POS_W-1:0]      step_r, step_nxt;
  logic [CHAN_W-1:0]     ch_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAN_W-1:0]     out_ch_r;
  logic signed [SAMPLE_BITS-1:0] out_smp_r;

  logic                  accept;
  logic [CHX-1:0]        ch_ext;
  logic                  ch_ok;
  logic [CH_IW-1:0]      ch_idx;
  logic [IXW-1:0]        cidx_ext;
  logic                  cidx_ok;
  logic                  smp_acc;
  logic [TCW-1:0]        t_ext;
  logic [TCW-1:0]        eff_w;
  logic [TAP_W-1:0]      eff;
  logic [POS_W-1:0]      eff_m1;
  logic [POS_W-1:0]      pos_rd;
  logic [TAP_W-1:0]      fill_rd;
  logic [POS_W-1:0]      pos_eff;
  logic [POS_W-1:0]      pos_next;
  logic [TAP_W-1:0]      pos_p1;
  logic                  emit;

  mcfir_cell_ctrl_t      cell_ctrl;
  mcfir_mac_ctrl_t       mac_ctrl;
  logic signed [SAMPLE_BITS-1:0] coef_vec [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] x_vec    [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] mac_res;

  // item decode
  assign accept   = in_tvalid && in_tready;
  assign ch_ext   = CHX'(in_ch);
  assign ch_ok    = (ch_ext < CHX'(CHANNELS));
  assign ch_idx   = ch_ext[CH_IW-1:0];
  assign cidx_ext = IXW'(in_cidx);
  assign cidx_ok  = (cidx_ext < IXW'(MAX_TAPS));
  assign smp_acc  = accept && !in_tuser && ch_ok;

  // effective tap count: zero means one, above the built maximum clamps
  always_comb begin
    t_ext = TCW'(tap_r);
    priority if (t_ext == '0) begin
      eff_w = TCW'(1);
    end else if (t_ext > TCW'(MAX_TAPS)) begin
      eff_w = TCW'(MAX_TAPS);
    end else begin
      eff_w = t_ext;
    end
  end
  assign eff    = eff_w[TAP_W-1:0];
  assign eff_m1 = POS_W'(eff - 1'b1);

  // write position of the channel, restarting if the tap count shrank
  assign pos_rd   = pos_tab_r[ch_idx];
  assign fill_rd  = fill_tab_r[ch_idx];
  assign pos_eff  = (TAP_W'(pos_rd) >= eff) ? '0 : pos_rd;
  assign pos_next = (pos_eff == eff_m1) ? '0 : POS_W'(pos_eff + 1'b1);
  assign pos_p1   = TAP_W'(pos_eff) + 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= TAPCFG_W'(1);
    end else if (cfg_wen) begin
      tap_r <= cfg_wdata;
    end
  end

  // per-channel write position and fill mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pos_tab_r[i]  <= '0;
        fill_tab_r[i] <= '0;
      end
    end else if (smp_acc) begin
      pos_tab_r[ch_idx] <= pos_next;
      if (pos_p1 > fill_rd) begin
        fill_tab_r[ch_idx] <= pos_p1;
      end
    end
  end

  // sequencer
  assign emit = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt   = state_r;
    taps_m1_nxt = taps_m1_r;
    at_nxt      = at_r;
    step_nxt    = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (smp_acc) begin
          state_nxt   = ST_MAC;
          taps_m1_nxt = eff_m1;
          at_nxt      = pos_eff;
          step_nxt    = '0;
        end
      end
      ST_MAC: begin
        at_nxt   = (at_r == '0) ? taps_m1_r : POS_W'(at_r - 1'b1);
        step_nxt = POS_W'(step_r + 1'b1);
        if (step_r == taps_m1_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    taps_m1_r <= taps_m1_nxt;
    at_r      <= at_nxt;
    step_r    <= step_nxt;
    if (smp_acc) begin
      ch_r <= in_ch;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  // cell and MAC control
  assign cell_ctrl.load    = smp_acc;
  assign cell_ctrl.shift   = (state_r == ST_MAC);
  assign cell_ctrl.coef_we = accept && in_tuser && cidx_ok;
  assign mac_ctrl.clear    = smp_acc;
  assign mac_ctrl.mul_en   = (state_r == ST_MAC);

  // row of tap cells
  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] nxt_c;
    if (j == MAX_TAPS - 1) begin : g_last
      assign nxt_c = coef_vec[0];
    end else begin : g_mid
      assign nxt_c = coef_vec[j+1];
    end
    mcfir_cell #(
      .MAX_TAPS    (MAX_TAPS),
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .J           (j)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .taps_m1    (taps_m1_r),
      .wr_pos     (pos_eff),
      .coef_idx   (cidx_ext[POS_W-1:0]),
      .fill       (fill_rd),
      .ch_idx     (ch_idx),
      .sample     (in_smp),
      .coef_wdata (in_cval),
      .next_coef  (nxt_c),
      .head_coef  (coef_vec[0]),
      .coef_o     (coef_vec[j]),
      .x_o        (x_vec[j])
    );
  end

  // single multiply-accumulate unit fed by the ring head and the selected tap
  mcfir_mac #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .coef   (coef_vec[0]),
    .x      (x_vec[at_r]),
    .result (mac_res)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch_r  <= ch_r;
      out_smp_r <= mac_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({out_smp_r, out_ch_r});

endmodule

/* rtl/core/mcfir_checker.sv */
// Port-level checks for the multichannel FIR filter, bound to the top level.
module mcfir_checker #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 24
) (
  input logic clk,
  input logic rst_n,
  input logic [((2*SAMPLE_BITS+mcfir_pkg::CHAN_W+mcfir_pkg::CIDX_W+7)/8)*8-1:0] in_tdata,
  input logic                                   in_tuser,
  input logic                                   in_tvalid,
  input logic                                   in_tready,
  input logic [((SAMPLE_BITS+mcfir_pkg::CHAN_W+7)/8)*8-1:0] out_tdata,
  input logic                                   out_tvalid,
  input logic                                   out_tready
);
  import mcfir_pkg::*;

  logic smp_item;
  logic load_item;

  assign smp_item  = in_tvalid && in_tready && !in_tuser &&
                     (in_tdata[CHAN_W-1:0] < CHANNELS);
  assign load_item = in_tvalid && in_tready && in_tuser;

  // a waiting result item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item withdrawn before it was taken");

  // a waiting result item keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result item changed while stalled");

  // a sample item keeps the block busy in the next cycle
  a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
    smp_item |=> !in_tready)
    else $error("input ready straight after a sample item");

  // a coefficient load leaves the block ready in the next cycle
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    load_item |=> in_tready)
    else $error("coefficient load held the input");

  // a new result appears only as the block returns to ready
  a_result_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result item raised while a sample is still in work");

endmodule

bind multichannel_fir_filter mcfir_checker #(
  .CHANNELS    (CHANNELS),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mcfir_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

/* tb/multichannel_fir_filter_checker.sv */
// Item codes, result predictor and result scoreboard for the multichannel FIR testbench.
package mcfir_tb_pkg;

  // What an input item carries, as sent on in_tuser
  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_COEFF  = 1'b1
  } mcfir_action_t;

endpackage

module multichannel_fir_filter_checker #(
  parameter int MAX_TAPS    = 64,
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata, lowest bit first: channel, sample, coeff_index, coeff_value, zero fill
  input  logic [((2*SAMPLE_BITS+mcfir_pkg::CHAN_W+mcfir_pkg::CIDX_W+7)/8)*8-1:0] in_tdata,
  // in_tuser: action
  input  logic                                   in_tuser,
  input  logic                                   in_tvalid,
  input  logic                                   in_tready,
  // out_tdata, lowest bit first: out_channel, filtered_sample, zero fill
  input  logic [((SAMPLE_BITS+mcfir_pkg::CHAN_W+7)/8)*8-1:0] out_tdata,
  input  logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic                                   cfg_wen,
  input  logic [mcfir_pkg::TAPCFG_W-1:0]         cfg_wdata,
  output int                                     err_count,
  output int                                     pend_count
);
  import mcfir_tb_pkg::*;

  localparam int CH_W = mcfir_pkg::CHAN_W;
  localparam int IX_W = mcfir_pkg::CIDX_W;
  localparam int FRAC = SAMPLE_BITS - 1;

  typedef struct packed {
    logic [CH_W-1:0]        chan;
    logic [SAMPLE_BITS-1:0] value;
  } fir_result_t;

  // Filter state as the block should hold it
  logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] line_mem [CHANNELS][MAX_TAPS];
  int unsigned                   wr_pos   [CHANNELS];
  logic [mcfir_pkg::TAPCFG_W-1:0] taps_reg;

  fir_result_t expected_q [$];
  int          mismatches;

  // Push one sample into the channel's delay line and work out the filter output
  function automatic logic [SAMPLE_BITS-1:0] filter_sample(input int unsigned ch,
                                                           input logic signed [SAMPLE_BITS-1:0] x);
    int unsigned n;
    int unsigned p;
    int unsigned at;
    longint      acc;
    longint      y;
    longint      lim;
    n = (taps_reg == 0) ? 1 : (taps_reg > MAX_TAPS) ? MAX_TAPS : int'(taps_reg);
    p = wr_pos[ch];
    // position left over from a larger tap count restarts the line
    if (p >= n) p = 0;
    line_mem[ch][p] = x;
    // products are Q2.46; 64 of them never reach the 64-bit limits
    acc = 0;
    for (int unsigned k = 0; k < n; k++) begin
      at  = (p >= k) ? p - k : p + n - k;
      acc = acc + longint'(coef_mem[k]) * longint'(line_mem[ch][at]);
    end
    wr_pos[ch] = (p + 1 == n) ? 0 : p + 1;
    // round half up, then saturate to Q1.23
    lim = longint'(1) <<< FRAC;
    y   = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    if (y > lim - 1) y = lim - 1;
    else if (y < -lim) y = -lim;
    return y[SAMPLE_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    logic [CH_W-1:0]        in_ch;
    logic [SAMPLE_BITS-1:0] in_smp;
    logic [IX_W-1:0]        in_idx;
    logic [SAMPLE_BITS-1:0] in_cv;
    fir_result_t            got;
    fir_result_t            want;
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wr_pos[c] = 0;
        for (int k = 0; k < MAX_TAPS; k++) line_mem[c][k] = '0;
      end
      for (int k = 0; k < MAX_TAPS; k++) coef_mem[k] = '0;
      taps_reg = 1;
      expected_q.delete();
      mismatches = 0;
      err_count  <= 0;
      pend_count <= 0;
    end else begin
      // tap count is only written while the block is idle
      if (cfg_wen) taps_reg = cfg_wdata;

      // accepted input item
      if (in_tvalid && in_tready) begin
        in_ch  = in_tdata[CH_W-1:0];
        in_smp = in_tdata[CH_W +: SAMPLE_BITS];
        in_idx = in_tdata[CH_W+SAMPLE_BITS +: IX_W];
        in_cv  = in_tdata[CH_W+SAMPLE_BITS+IX_W +: SAMPLE_BITS];
        if (in_tuser == ACT_COEFF) begin
          if (in_idx < MAX_TAPS) coef_mem[in_idx] = in_cv;
        end else if (in_ch < CHANNELS) begin
          want.chan  = in_ch;
          want.value = filter_sample(in_ch, in_smp);
          expected_q.push_back(want);
        end
      end

      // accepted result item
      if (out_tvalid && out_tready) begin
        got.chan  = out_tdata[CH_W-1:0];
        got.value = out_tdata[CH_W +: SAMPLE_BITS];
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected: channel %0d sample %06h",
                   $time, got.chan, got.value);
        end else begin
          want = expected_q.pop_front();
          if (got.chan !== want.chan || got.value !== want.value) begin
            mismatches++;
            $display("%0t: mismatch: expected channel %0d sample %06h, got channel %0d sample %06h",
                     $time, want.chan, want.value, got.chan, got.value);
          end
        end
      end

      err_count  <= mismatches;
      pend_count <= expected_q.size();
    end
  end

endmodule

/* tb/multichannel_fir_filter_tb.sv */
// Testbench top for the multichannel FIR filter: clock, reset, stimulus, result sink and verdict.
module multichannel_fir_filter_tb;
  import mcfir_tb_pkg::*;

  localparam int MAX_TAPS    = 64;
  localparam int CHANNELS    = 8;
  localparam int SAMPLE_BITS = 24;
  localparam int CH_W  = mcfir_pkg::CHAN_W;
  localparam int IX_W  = mcfir_pkg::CIDX_W;
  localparam int TC_W  = mcfir_pkg::TAPCFG_W;
  localparam int IN_W  = ((2*SAMPLE_BITS+mcfir_pkg::CHAN_W+mcfir_pkg::CIDX_W+7)/8)*8;
  localparam int OUT_W = ((SAMPLE_BITS+mcfir_pkg::CHAN_W+7)/8)*8;
  // longest sample item uses MAX_TAPS taps; leave a margin
  localparam int DRAIN_CYCLES = MAX_TAPS + 16;
  localparam int RANDOM_ITEMS = 1400;

  localparam logic [SAMPLE_BITS-1:0] S_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] S_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] S_HALF = {2'b01, {(SAMPLE_BITS-2){1'b0}}};

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic [IN_W-1:0]                in_tdata;
  logic                           in_tuser;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [OUT_W-1:0]               out_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic                           cfg_wen;
  logic [mcfir_pkg::TAPCFG_W-1:0] cfg_wdata;
  int                             err_count;
  int                             pend_count;

  bit send_calm;
  bit sink_calm;
  int sent;

  always #5 clk = ~clk;

  multichannel_fir_filter #(
    .MAX_TAPS   (MAX_TAPS),
    .CHANNELS   (CHANNELS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  multichannel_fir_filter_checker #(
    .MAX_TAPS   (MAX_TAPS),
    .CHANNELS   (CHANNELS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .err_count (err_count),
    .pend_count(pend_count)
  );

  // Present one item after a random gap and hold it until taken
  task automatic send_item(input mcfir_action_t act, input logic [mcfir_pkg::CHAN_W-1:0] ch,
                           input logic [SAMPLE_BITS-1:0] smp,
                           input logic [mcfir_pkg::CIDX_W-1:0] idx,
                           input logic [SAMPLE_BITS-1:0] cv);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= act;
    in_tdata  <= IN_W'({cv, idx, smp, ch});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // Unused fields carry random bits so every input bit toggles
  task automatic load_coeff(input int unsigned idx, input logic [SAMPLE_BITS-1:0] cv);
    send_item(ACT_COEFF, CH_W'($urandom), SAMPLE_BITS'($urandom), IX_W'(idx), cv);
  endtask

  task automatic send_sample(input int unsigned ch, input logic [SAMPLE_BITS-1:0] x);
    send_item(ACT_SAMPLE, CH_W'(ch), x, IX_W'($urandom), SAMPLE_BITS'($urandom));
  endtask

  // Hold off until every result is back and the block has gone quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pend_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_taps(input int unsigned n);
    cfg_wdata <= TC_W'(n);
    cfg_wen   <= 1'b1;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // Mostly full-range values, with the extremes and tiny magnitudes mixed in
  function automatic logic [SAMPLE_BITS-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return SAMPLE_BITS'($signed($urandom_range(0, 8)) - 4);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Result sink: random stall per item, sometimes a run with none
  initial begin
    int unsigned stall;
    out_tready <= 1'b0;
    sink_calm = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 29) == 0) sink_calm = !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned len;
    rst_n     <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    in_tvalid <= 1'b0;
    cfg_wen   <= 1'b0;
    cfg_wdata <= '0;
    send_calm = 1'b0;
    sent      = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tap count zero acts as a single tap
    write_taps(0);
    load_coeff(0, S_MAX);
    send_sample(0, S_MAX);
    send_sample(7, S_MIN);
    send_sample(3, 1);
    send_sample(5, '1);
    settle();

    // two taps of minus one: minus times minus saturates high
    write_taps(2);
    load_coeff(0, S_MIN);
    load_coeff(1, S_MIN);
    send_sample(1, S_MIN);
    send_sample(1, S_MIN);
    send_sample(6, S_MAX);
    // half an LSB rounds up, minus half rounds to zero
    load_coeff(0, S_HALF);
    load_coeff(1, 0);
    send_sample(2, 1);
    send_sample(4, '1);
    settle();

    // channel 4 left at position 2, then the tap count shrinks below it
    write_taps(3);
    load_coeff(2, S_MAX);
    send_sample(4, S_MAX);
    settle();
    write_taps(2);
    send_sample(4, S_MIN);
    send_sample(4, 3);
    settle();

    // every coefficient gets a value before the wide settings are used
    sent = 0;
    for (int k = 0; k < MAX_TAPS; k++) load_coeff(k, pick_value());

    // random phases, each with its own tap count
    while (sent < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 9))
        0:       write_taps(0);
        1:       write_taps(1);
        2:       write_taps(MAX_TAPS);
        3:       write_taps(127);
        4:       write_taps($urandom_range(MAX_TAPS + 1, 126));
        5:       write_taps($urandom_range(17, MAX_TAPS - 1));
        default: write_taps($urandom_range(1, 16));
      endcase
      send_calm = ($urandom_range(0, 3) == 0);
      len = $urandom_range(20, 80);
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(0, 6) == 0) load_coeff($urandom_range(0, MAX_TAPS - 1), pick_value());
        else send_sample($urandom_range(0, CHANNELS - 1), pick_value());
      end
    end

    send_calm = 1'b0;
    settle();
    if (err_count == 0 && pend_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Timeout
  initial begin
    #(8_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* multichannel_fir_filter.f */
rtl/core/mcfir_pkg.sv
rtl/core/mcfir_cell.sv
rtl/core/mcfir_mac.sv
rtl/core/multichannel_fir_filter.sv
rtl/core/mcfir_checker.sv
tb/multichannel_fir_filter_checker.sv
tb/multichannel_fir_filter_tb.sv
